### rtl/fsx_pkg.sv
// fsx_pkg: shared constants and types for the fp32 saxpy element core
// no dependencies
package fsx_pkg;

	localparam logic [31:0] QNAN_DEFAULT = 32'hFFC00000;
	localparam logic [31:0] QUIET_BIT    = 32'h00400000;
	localparam logic [7:0]  EXP_ONES     = 8'hFF;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic        last;
	} fsx_item_t;

	typedef struct packed {
		logic [31:0] y;
		logic [31:0] p;
		logic        last;
	} fsx_mid_t;

	function automatic logic is_nan(input logic [31:0] v);
		return (v[30:23] == EXP_ONES) && (v[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(input logic [31:0] v);
		return (v[30:23] == EXP_ONES) && (v[22:0] == 23'd0);
	endfunction

	// pack a 2^23..2^25 scaled significand: m holds 24-bit value plus guard/round/sticky
	// m: [26:3] significand with hidden bit at 26, [2:0] grs; e biased exponent of bit 26
	function automatic logic [31:0] round_norm(input logic sign, input logic signed [10:0] e,
			input logic [26:0] m);
		logic [24:0] q;
		logic [31:0] r;
		logic        up;
		up = m[2] & (m[1] | m[0] | m[3]);
		q = {1'b0, m[26:3]} + {24'd0, up};
		r = 32'd0;
		if (e >= 11'sd255) begin
			r = {sign, EXP_ONES, 23'd0};
		end else begin
			// q[23] set means normal with exp e; e==1 with q[23]==0 is subnormal
			r = {sign, 31'd0} + ({1'b0, 31'(e - 11'sd1)} << 23) + {7'd0, q};
			if (r[30:23] == EXP_ONES) r = {sign, EXP_ONES, 23'd0};
		end
		return r;
	endfunction

endpackage

### rtl/fsx_mul.sv
// fsx_mul: fp32 multiply, round to nearest even, subnormals kept
// depends on fsx_pkg
module fsx_mul
	import fsx_pkg::*;
(
	input  logic [31:0] x,
	input  logic [31:0] a,
	output logic [31:0] p
);

	logic        sgn;
	logic [23:0] mx, ma;
	logic [47:0] prod;
	logic signed [10:0] ex, ea, e0, e;
	logic [5:0]  lz;
	logic [5:0]  sh;
	logic [47:0] nrm;
	logic [73:0] ext;
	logic [73:0] shr;
	logic [26:0] m;
	logic        stk;

	always_comb begin
		sgn = x[31] ^ a[31];
		mx = {x[30:23] != 8'd0, x[22:0]};
		ma = {a[30:23] != 8'd0, a[22:0]};
		ex = (x[30:23] == 8'd0) ? 11'sd1 : {3'd0, x[30:23]};
		ea = (a[30:23] == 8'd0) ? 11'sd1 : {3'd0, a[30:23]};
		prod = mx * ma;
		lz = 6'd0;
		for (int i = 0; i < 48; i++) begin
			if (prod[i]) lz = 6'(47 - i);
		end
		// value prod*2^(ex+ea-300); bit 47 weight has exponent ex+ea-127+1
		e0 = ex + ea - 11'sd126;
		e = e0 - 11'(signed'({5'd0, lz}));
		sh = lz;
		if (e < 11'sd1) begin
			if (11'(lz) < 11'(11'sd1 - e)) begin
				sh = 6'd0;
			end else begin
				sh = 6'(11'(lz) - (11'sd1 - e));
			end
		end
		nrm = prod << sh;
		ext = {nrm, 26'd0};
		shr = ext;
		if (e < 11'sd1 && lz < 11'(11'sd1 - e) && (11'sd1 - e - 11'(lz)) > 11'sd0) begin
			shr = ext >> (11'sd1 - e - 11'(lz) > 11'sd60 ? 7'd60 : 7'(11'sd1 - e - 11'(lz)));
		end
		if (e < 11'sd1) e = 11'sd1;
		stk = |shr[47:0];
		m = {shr[73:48], stk};
		p = round_norm(sgn, e, m);
		if (mx == 24'd0 || ma == 24'd0) p = {sgn, 31'd0};
		if (is_inf(x) || is_inf(a)) begin
			p = (x[30:0] == 31'd0 || a[30:0] == 31'd0) ? QNAN_DEFAULT : {sgn, EXP_ONES, 23'd0};
		end
		if (is_nan(a)) p = a | QUIET_BIT;
		if (is_nan(x)) p = x | QUIET_BIT;
	end

endmodule

### rtl/fsx_add.sv
// fsx_add: fp32 add, round to nearest even, subnormals kept
// depends on fsx_pkg
module fsx_add
	import fsx_pkg::*;
(
	input  logic [31:0] y,
	input  logic [31:0] p,
	output logic [31:0] s
);

	logic        swp, shi, slo, rs;
	logic [31:0] hv, lv;
	logic [7:0]  eh, el;
	logic [8:0]  d;
	logic [26:0] hm, lm, lsh;
	logic [27:0] sum;
	logic [4:0]  lz;
	logic signed [10:0] e;
	logic [27:0] nrm;
	logic [26:0] m;

	always_comb begin
		swp = p[30:0] > y[30:0];
		hv = swp ? p : y;
		lv = swp ? y : p;
		shi = hv[31];
		slo = lv[31];
		eh = (hv[30:23] == 8'd0) ? 8'd1 : hv[30:23];
		el = (lv[30:23] == 8'd0) ? 8'd1 : lv[30:23];
		hm = {hv[30:23] != 8'd0, hv[22:0], 3'd0};
		lm = {lv[30:23] != 8'd0, lv[22:0], 3'd0};
		d = {1'b0, eh} - {1'b0, el};
		lsh = lm;
		if (d >= 9'd27) begin
			lsh = {26'd0, lm != 27'd0};
		end else if (d != 9'd0) begin
			lsh = (lm >> d[4:0]) | {26'd0, (lm & ~(27'h7FFFFFF << d[4:0])) != 27'd0};
		end
		rs = shi;
		sum = (shi == slo) ? {1'b0, hm} + {1'b0, lsh} : {1'b0, hm} - {1'b0, lsh};
		lz = 5'd0;
		for (int i = 0; i < 27; i++) begin
			if (sum[i]) lz = 5'(27 - i);
		end
		e = 11'(signed'({3'd0, eh})) + 11'sd1;
		nrm = sum;
		if (sum[27]) begin
			m = {sum[27:2], sum[1] | sum[0]};
		end else begin
			if (11'(lz) - 11'sd1 > e - 11'sd2) begin
				nrm = sum << 5'(e - 11'sd2);
				e = 11'sd1;
			end else begin
				nrm = sum << (lz - 5'd1);
				e = e - 11'(lz);
			end
			m = nrm[26:0];
		end
		s = (sum == 28'd0) ? 32'd0 : round_norm(rs, e, m);
		if (y[30:0] == 31'd0 && p[30:0] == 31'd0) s = {y[31] & p[31], 31'd0};
		if (is_inf(p)) s = p;
		if (is_inf(y)) s = y;
		if (is_inf(y) && is_inf(p)) s = (y[31] == p[31]) ? y : QNAN_DEFAULT;
		if (is_nan(p)) s = p | QUIET_BIT;
		if (is_nan(y)) s = y | QUIET_BIT;
	end

endmodule

### rtl/fp32_saxpy_element_core.sv
// fp32_saxpy_element_core: top level, y + a*x on fp32 words
// depends on fsx_pkg, fsx_mul, fsx_add
//
// s_axis carries one x,y pair per item with tlast marking the end of a range;
// m_axis returns new_y with tlast copied.
// scale_factor is written through cfg_we/cfg_wdata; reset gives 1.0. the user
// writes it only while idle; the core does not enforce it. an item enters an
// input register, the multiply into a stage register, the add into the output
// register. throughput one item per cycle; each stage holds when the next one
// is full and stalled, so a stalled receiver back-pressures s_axis_tready.
// reset empties all stages; nothing is lost or repeated across stalls.
module fp32_saxpy_element_core
	import fsx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // x_value, y_value
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // new_y
	output logic        m_axis_tlast
);

	logic [31:0] scale_q;
	fsx_item_t   in_s1;
	fsx_mid_t    mid_s2;
	logic        v1_q, v2_q, v3_q;
	logic [31:0] res_q;
	logic        last_q;
	logic [31:0] prod, sum;
	logic        en1, en2, en3;

	fsx_mul u_mul (.x(in_s1.x), .a(scale_q), .p(prod));
	fsx_add u_add (.y(mid_s2.y), .p(mid_s2.p), .s(sum));

	assign en3 = !v3_q || m_axis_tready;
	assign en2 = !v2_q || en3;
	assign en1 = !v1_q || en2;
	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 32'h3F800000;
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (cfg_we) scale_q <= cfg_wdata;
			if (en1) v1_q <= s_axis_tvalid;
			if (en2) v2_q <= v1_q;
			if (en3) v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) in_s1 <= '{x: s_axis_tdata[31:0], y: s_axis_tdata[63:32], last: s_axis_tlast};
		if (en2) mid_s2 <= '{y: in_s1.y, p: prod, last: in_s1.last};
		if (en3) begin
			res_q <= sum;
			last_q <= mid_s2.last;
		end
	end

	assign m_axis_tvalid = v3_q;
	assign m_axis_tdata = res_q;
	assign m_axis_tlast = last_q;

endmodule

### dv/fsx_checker.sv
// fsx_checker: watches both stream channels of the fp32 saxpy core, predicts new_y
// from its own copy of the scale factor and compares each returned item in order
// depends on fsx_pkg for the default nan constant
`timescale 1ns / 100ps
module fsx_checker
	import fsx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,
	input  logic        m_axis_tlast,
	output int          fail_count,
	output int          pending,
	output int          checked
);

	typedef struct {
		logic [31:0] y;
		logic        last;
	} saxpy_out_t;

	logic [31:0] scale;
	saxpy_out_t  expected_y_q[$];

	function automatic bit fnan(input logic [31:0] v);
		return v[30:23] == 8'hFF && v[22:0] != 0;
	endfunction

	function automatic bit finf(input logic [31:0] v);
		return v[30:0] == 31'h7F800000;
	endfunction

	function automatic void unpack_fp(input logic [31:0] v, output logic [63:0] m, output int e);
		if (v[30:23] == 0) begin
			m = {41'd0, v[22:0]};
			e = 1;
		end else begin
			m = {40'd0, 1'b1, v[22:0]};
			e = v[30:23];
		end
	endfunction

	function automatic logic [31:0] round_to_fp(input logic sgn, input int ex, input logic [63:0] sig);
		int msb, s, bexp;
		logic [63:0] q, r, half;
		logic [63:0] bits;
		msb = 63;
		while (msb > 0 && !sig[msb]) msb--;
		s = msb - 23;
		if (s < -149 - ex) s = -149 - ex;
		bexp = ex + s + 150;
		if (bexp >= 255) return {sgn, 31'h7F800000};
		if (s <= 0) q = sig << (-s);
		else if (s >= 64) q = 0;
		else begin
			r = sig & ((64'd1 << s) - 1);
			half = 64'd1 << (s - 1);
			q = sig >> s;
			if (r > half || (r == half && q[0])) q++;
		end
		bits = (64'(bexp - 1) << 23) + q;
		if (bits >= 64'h7F800000) return {sgn, 31'h7F800000};
		return {sgn, bits[30:0]};
	endfunction

	function automatic logic [31:0] fp_mul(input logic [31:0] x, input logic [31:0] a);
		logic sgn;
		logic [63:0] mx, ma;
		int ex, ea;
		sgn = x[31] ^ a[31];
		if (fnan(x)) return x | 32'h00400000;
		if (fnan(a)) return a | 32'h00400000;
		if (finf(x) || finf(a)) begin
			if (x[30:0] == 0 || a[30:0] == 0) return QNAN_DEFAULT;
			return {sgn, 31'h7F800000};
		end
		unpack_fp(x, mx, ex);
		unpack_fp(a, ma, ea);
		if (mx == 0 || ma == 0) return {sgn, 31'd0};
		return round_to_fp(sgn, ex + ea - 300, mx * ma);
	endfunction

	function automatic logic [31:0] fp_add(input logic [31:0] y, input logic [31:0] p);
		logic [63:0] my, mp, hi, lo, lost;
		int ey, ep, eh, el, d;
		logic shi, slo, rs;
		if (fnan(y)) return y | 32'h00400000;
		if (fnan(p)) return p | 32'h00400000;
		if (finf(y) && finf(p)) return (y[31] == p[31]) ? y : QNAN_DEFAULT;
		if (finf(y)) return y;
		if (finf(p)) return p;
		unpack_fp(y, my, ey);
		unpack_fp(p, mp, ep);
		if (my == 0 && mp == 0) return {y[31] & p[31], 31'd0};
		if (ey >= ep) begin
			hi = my; eh = ey; shi = y[31]; lo = mp; el = ep; slo = p[31];
		end else begin
			hi = mp; eh = ep; shi = p[31]; lo = my; el = ey; slo = y[31];
		end
		hi <<= 8;
		lo <<= 8;
		d = eh - el;
		if (d >= 64) lo = (lo != 0);
		else if (d > 0) begin
			lost = lo & ((64'd1 << d) - 1);
			lo = (lo >> d) | (lost != 0);
		end
		if (shi == slo) begin
			hi += lo; rs = shi;
		end else if (hi >= lo) begin
			hi -= lo; rs = shi;
		end else begin
			hi = lo - hi; rs = slo;
		end
		if (hi == 0) return 32'd0;
		return round_to_fp(rs, eh - 158, hi);
	endfunction

	assign pending = expected_y_q.size();

	always @(posedge clk or negedge arst_n) begin
		saxpy_out_t e, got;
		if (!arst_n) begin
			scale <= 32'h3F800000;
			fail_count <= 0;
			checked <= 0;
			expected_y_q.delete();
		end else begin
			if (cfg_we) scale <= cfg_wdata;
			if (s_axis_tvalid && s_axis_tready) begin
				e.y = fp_add(s_axis_tdata[63:32], fp_mul(s_axis_tdata[31:0], scale));
				e.last = s_axis_tlast;
				expected_y_q.push_back(e);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.y = m_axis_tdata;
				got.last = m_axis_tlast;
				checked <= checked + 1;
				if (expected_y_q.size() == 0) begin
					if (fail_count < 10) $display("unexpected item: y=%h last=%b", got.y, got.last);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_y_q.pop_front();
					if (e.y !== got.y || e.last !== got.last) begin
						if (fail_count < 10)
							$display("mismatch: expected y=%h last=%b, got y=%h last=%b",
								e.y, e.last, got.y, got.last);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

### dv/tb.sv
// tb: stimulus and verdict for fp32_saxpy_element_core
// depends on fsx_pkg, the core rtl and dv/fsx_checker.sv
`timescale 1ns / 100ps
module tb;
	import fsx_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [31:0] cfg_wdata = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = 0;  // x_value, y_value
	logic        s_axis_tlast = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [31:0] m_axis_tdata;      // new_y
	logic        m_axis_tlast;
	int          fail_count, pending, checked;
	bit          calm = 0;
	int          sent = 0;

	always #10 clk = ~clk;

	fp32_saxpy_element_core DUT (.*);
	fsx_checker u_checker (.*);

	function automatic logic [31:0] pick_fp();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0: v[30:23] = 8'hFF;
			1: v[30:23] = 8'h00;
			2: v[30:0] = $urandom_range(0, 1) ? 31'h7F800000 : 31'd0;
			3: v[30:23] = $urandom_range(1, 20);
			4: v[30:23] = $urandom_range(235, 254);
			5: v[30:23] = $urandom_range(100, 150);
			default: v[30:23] = $urandom_range(110, 140);
		endcase
		return v;
	endfunction

	task automatic send_pair(input logic [31:0] x, input logic [31:0] y, input logic last);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 0;
			gap = $urandom_range(1, 3);
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {y, x};
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		sent++;
	endtask

	task automatic drain_and_scale(input logic [31:0] a);
		s_axis_tvalid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (5) @(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= a;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	always begin
		int gap;
		@(negedge clk);
		if (!calm && $urandom_range(0, 4) == 0) begin
			m_axis_tready <= 0;
			gap = $urandom_range(1, 3);
			repeat (gap - 1) @(negedge clk);
		end else m_axis_tready <= 1;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [31:0] special[12];
		logic [31:0] scales[8];
		special = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
			32'h7FC00001, 32'hFF800123, 32'h00000001, 32'h807FFFFF,
			32'h7F7FFFFF, 32'hFF7FFFFF, 32'h3F800000, 32'hBF800000};
		scales = '{32'h3F800000, 32'h00000000, 32'h7F800000, 32'h7FA00000,
			32'hFF7FFFFF, 32'h00000001, 32'hC0400000, 32'h80000000};
		repeat (10) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// default scale first, then directed extremes and special cases
		for (int i = 0; i < 12; i++) send_pair(special[i], special[11 - i], i[0]);
		send_pair(32'h7F800000, 32'hFF800000, 0);
		send_pair(32'h7F400000, 32'h7F400000, 0);
		send_pair(32'h3F800000, 32'hBF800000, 0);
		send_pair(32'h80000000, 32'h80000000, 0);
		send_pair(32'h7FA00000, 32'hFFC00005, 0);
		send_pair(32'hFFFFFFFF, 32'hFFFFFFFF, 1);
		for (int p = 0; p < 8; p++) begin
			drain_and_scale(scales[p]);
			send_pair(32'h00000000, 32'h3F800000, 0);
			send_pair(32'h7FC00000, 32'h00000000, 1);
			for (int n = 0; n < 45; n++) send_pair(pick_fp(), pick_fp(), $urandom_range(0, 1));
		end
		for (int p = 0; p < 12; p++) begin
			drain_and_scale(p == 11 ? 32'hFFFFFFFF : pick_fp());
			if (p >= 10) calm = 1;
			for (int n = 0; n < 50; n++) send_pair(pick_fp(), pick_fp(), $urandom_range(0, 1));
		end
		s_axis_tvalid <= 0;
		for (int w = 0; w < 10000 && pending != 0; w++) @(negedge clk);
		repeat (10) @(negedge clk);
		$display("sent %0d x/y pairs over 21 scale settings, %0d results checked",
			sent, checked);
		if (fail_count == 0 && pending == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

endmodule
